// File: rtl/tbcl_pkg.sv
`timescale 1ns / 1ps

package tbcl_pkg;

   // cache geometry
   localparam int NUM_LINES = 8;
   localparam int LINE_W    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
   localparam int CNT_W     = $clog2(NUM_LINES + 1);

   // field widths
   localparam int DEV_W      = 2;
   localparam int LSEC_W     = 16;
   localparam int SPT_W      = 6;
   localparam int BUFS_W     = 4;
   localparam int TRACK_W    = 8;
   localparam int LINE_OUT_W = 3;
   localparam int USE_W      = 8;

   // divider sequencing, one quotient bit per cycle
   localparam int DIV_STEPS = LSEC_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // use counter limits
   localparam logic [USE_W-1:0]   USE_MAX   = 8'd255;
   localparam logic [USE_W-1:0]   USE_FILL  = 8'd1;
   localparam logic [TRACK_W-1:0] TRACK_SAT = 8'd255;

   // control register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SPT_W;
   localparam logic [CSR_IDX_W-1:0] CSR_SECTORS_PER_TRACK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFERS_IN_USE    = 2'd1;

   localparam logic [SPT_W-1:0]  SPT_RESET  = 6'd18;
   localparam logic [BUFS_W-1:0] BUFS_RESET = 4'd8;

endpackage

// File: rtl/tbcl_if.sv
`timescale 1ns / 1ps

// sector request channel
interface tbcl_req_if;
   logic                         valid;
   logic                         ready;
   logic [tbcl_pkg::DEV_W-1:0]   device_minor;
   logic [tbcl_pkg::LSEC_W-1:0]  logical_sector;
   logic                         request_last;

   modport source (output valid, output device_minor, output logical_sector,
                   output request_last, input ready);
   modport sink   (input valid, input device_minor, input logical_sector,
                   input request_last, output ready);
endinterface

// lookup result channel
interface tbcl_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             hit;
   logic [tbcl_pkg::LINE_OUT_W-1:0]  line_index;
   logic [tbcl_pkg::TRACK_W-1:0]     track_number;
   logic [tbcl_pkg::SPT_W-1:0]       sector_in_track;
   logic                             range_error;
   logic                             result_last;

   modport source (output valid, output hit, output line_index, output track_number,
                   output sector_in_track, output range_error, output result_last,
                   input ready);
   modport sink   (input valid, input hit, input line_index, input track_number,
                   input sector_in_track, input range_error, input result_last,
                   output ready);
endinterface

// File: rtl/track_buffer_cache_lookup_core.sv
`timescale 1ns / 1ps

// Track buffer cache lookup. Each request (device, logical sector) is split
// into track and sector within the track by a restoring divider that yields one
// quotient bit per cycle, then the lines in use are scanned one per
// cycle for a valid line with matching device and track while the least used
// line is tracked as the victim. A hit bumps the line's saturating use counter;
// a miss retags the victim with counter 1. A request passes through accept,
// divide, a scan of up to the lines in use (fewer on an early hit), update
// and result steps; the result step waits for a free output register.
// A track above 255 skips the scan and returns range_error.
// One request is in flight at a time; a new request is taken while the last
// result still waits on the output register. Control registers may only be
// written while no request is in flight.
module track_buffer_cache_lookup_core (
   input  logic                                clock,
   input  logic                                reset,
   tbcl_req_if.sink                            req_if,
   tbcl_rsp_if.source                          rsp_if,
   input  logic                                csr_wr_en,
   input  logic [tbcl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tbcl_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_SCAN,
      S_UPDATE,
      S_DONE
   } state_type;

   // control state
   state_type                          state_ff, state_in;
   logic [tbcl_pkg::DIV_CNT_W-1:0]     bit_cnt_ff, bit_cnt_in;
   logic [tbcl_pkg::LINE_W-1:0]        idx_ff, idx_in;
   logic [tbcl_pkg::SPT_W-1:0]         cfg_spt_ff, cfg_spt_in;
   logic [tbcl_pkg::BUFS_W-1:0]        cfg_bufs_ff, cfg_bufs_in;
   logic [tbcl_pkg::USE_W-1:0]         use_count_ff [tbcl_pkg::NUM_LINES];
   logic [tbcl_pkg::USE_W-1:0]         use_count_in [tbcl_pkg::NUM_LINES];
   logic                               rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [tbcl_pkg::LSEC_W-1:0]        quo_ff, quo_in;
   logic [tbcl_pkg::SPT_W-1:0]         rem_ff, rem_in;
   logic [tbcl_pkg::SPT_W-1:0]         spt_ff, spt_in;
   logic [tbcl_pkg::DEV_W-1:0]         dev_ff, dev_in;
   logic                               last_ff, last_in;
   logic                               err_ff, err_in;
   logic                               hit_ff, hit_in;
   logic [tbcl_pkg::LINE_W-1:0]        line_ff, line_in;
   logic [tbcl_pkg::LINE_W-1:0]        victim_ff, victim_in;
   logic [tbcl_pkg::USE_W-1:0]         best_ff, best_in;
   logic [tbcl_pkg::DEV_W-1:0]         line_device_ff [tbcl_pkg::NUM_LINES];
   logic [tbcl_pkg::TRACK_W-1:0]       line_track_ff  [tbcl_pkg::NUM_LINES];
   logic                               tag_we;
   logic [tbcl_pkg::LINE_W-1:0]        tag_addr;

   logic                               o_hit_ff, o_hit_in;
   logic [tbcl_pkg::LINE_OUT_W-1:0]    o_line_ff, o_line_in;
   logic [tbcl_pkg::TRACK_W-1:0]       o_track_ff, o_track_in;
   logic [tbcl_pkg::SPT_W-1:0]         o_sector_ff, o_sector_in;
   logic                               o_err_ff, o_err_in;
   logic                               o_last_ff, o_last_in;

   // helpers
   logic                               req_fire;
   logic                               out_free;
   logic [tbcl_pkg::CNT_W-1:0]         n_lines;
   logic [tbcl_pkg::CNT_W-1:0]         last_idx;
   logic [tbcl_pkg::SPT_W:0]           rem_shift;
   logic                               rem_ge;
   logic [tbcl_pkg::USE_W-1:0]         cur_count;
   logic                               cur_match;
   logic [tbcl_pkg::LINE_W-1:0]        sel_line;

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   // lines in use, clamped to one and to the line count
   always_comb begin
      if (cfg_bufs_ff == '0) begin
         n_lines = tbcl_pkg::CNT_W'(1);
      end else if (8'(cfg_bufs_ff) > 8'(tbcl_pkg::NUM_LINES)) begin
         n_lines = tbcl_pkg::CNT_W'(tbcl_pkg::NUM_LINES);
      end else begin
         n_lines = tbcl_pkg::CNT_W'(cfg_bufs_ff);
      end
      last_idx = n_lines - tbcl_pkg::CNT_W'(1);
   end

   // one restoring division step
   assign rem_shift = {rem_ff, quo_ff[tbcl_pkg::LSEC_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, spt_ff});

   // line under scan
   assign cur_count = use_count_ff[idx_ff];
   assign cur_match = (cur_count != '0) && (line_device_ff[idx_ff] == dev_ff)
                      && (line_track_ff[idx_ff] == quo_ff[tbcl_pkg::TRACK_W-1:0]);
   assign sel_line  = hit_ff ? line_ff : victim_ff;

   // next state
   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      idx_in       = idx_ff;
      cfg_spt_in   = cfg_spt_ff;
      cfg_bufs_in  = cfg_bufs_ff;
      use_count_in = use_count_ff;
      rsp_valid_in = rsp_valid_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      spt_in       = spt_ff;
      dev_in       = dev_ff;
      last_in      = last_ff;
      err_in       = err_ff;
      hit_in       = hit_ff;
      line_in      = line_ff;
      victim_in    = victim_ff;
      best_in      = best_ff;
      tag_we       = 1'b0;
      tag_addr     = victim_ff;
      o_hit_in     = o_hit_ff;
      o_line_in    = o_line_ff;
      o_track_in   = o_track_ff;
      o_sector_in  = o_sector_ff;
      o_err_in     = o_err_ff;
      o_last_in    = o_last_ff;

      // register writes
      if (csr_wr_en) begin
         case (csr_index)
            tbcl_pkg::CSR_SECTORS_PER_TRACK: cfg_spt_in  = csr_wdata[tbcl_pkg::SPT_W-1:0];
            tbcl_pkg::CSR_BUFFERS_IN_USE:    cfg_bufs_in = csr_wdata[tbcl_pkg::BUFS_W-1:0];
            default: ;
         endcase
      end

      // result handed over
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               quo_in     = req_if.logical_sector;
               rem_in     = '0;
               spt_in     = (cfg_spt_ff == '0) ? tbcl_pkg::SPT_W'(1) : cfg_spt_ff;
               dev_in     = req_if.device_minor;
               last_in    = req_if.request_last;
               bit_cnt_in = '0;
               state_in   = S_DIV;
            end
         end
         S_DIV: begin
            quo_in     = {quo_ff[tbcl_pkg::LSEC_W-2:0], rem_ge};
            rem_in     = rem_ge ? tbcl_pkg::SPT_W'(rem_shift - {1'b0, spt_ff})
                                : rem_shift[tbcl_pkg::SPT_W-1:0];
            bit_cnt_in = bit_cnt_ff + tbcl_pkg::DIV_CNT_W'(1);
            if (bit_cnt_ff == tbcl_pkg::DIV_CNT_W'(tbcl_pkg::DIV_STEPS - 1)) begin
               err_in    = |quo_in[tbcl_pkg::LSEC_W-1:tbcl_pkg::TRACK_W];
               hit_in    = 1'b0;
               line_in   = '0;
               best_in   = tbcl_pkg::USE_MAX;
               victim_in = tbcl_pkg::LINE_W'(last_idx);
               idx_in    = '0;
               state_in  = err_in ? S_DONE : S_SCAN;
            end
         end
         S_SCAN: begin
            // first matching line wins
            if (cur_match) begin
               hit_in  = 1'b1;
               line_in = idx_ff;
            end
            // first line with the lowest counter below saturation
            if (cur_count < best_ff) begin
               best_in   = cur_count;
               victim_in = idx_ff;
            end
            idx_in = idx_ff + tbcl_pkg::LINE_W'(1);
            if (cur_match || (tbcl_pkg::CNT_W'(idx_ff) == last_idx)) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (hit_ff) begin
               if (use_count_ff[line_ff] != tbcl_pkg::USE_MAX) begin
                  use_count_in[line_ff] = use_count_ff[line_ff] + tbcl_pkg::USE_W'(1);
               end
            end else begin
               use_count_in[victim_ff] = tbcl_pkg::USE_FILL;
               tag_we                  = 1'b1;
               tag_addr                = victim_ff;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               o_hit_in     = hit_ff && !err_ff;
               o_line_in    = err_ff ? '0 : tbcl_pkg::LINE_OUT_W'(sel_line);
               o_track_in   = err_ff ? tbcl_pkg::TRACK_SAT : quo_ff[tbcl_pkg::TRACK_W-1:0];
               o_sector_in  = rem_ff;
               o_err_in     = err_ff;
               o_last_in    = last_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers and state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bit_cnt_ff   <= '0;
         idx_ff       <= '0;
         cfg_spt_ff   <= tbcl_pkg::SPT_RESET;
         cfg_bufs_ff  <= tbcl_pkg::BUFS_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < tbcl_pkg::NUM_LINES; i++) begin
            use_count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         idx_ff       <= idx_in;
         cfg_spt_ff   <= cfg_spt_in;
         cfg_bufs_ff  <= cfg_bufs_in;
         rsp_valid_ff <= rsp_valid_in;
         use_count_ff <= use_count_in;
      end
   end

   // payload registers and line tags
   always_ff @(posedge clock) begin
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      spt_ff      <= spt_in;
      dev_ff      <= dev_in;
      last_ff     <= last_in;
      err_ff      <= err_in;
      hit_ff      <= hit_in;
      line_ff     <= line_in;
      victim_ff   <= victim_in;
      best_ff     <= best_in;
      o_hit_ff    <= o_hit_in;
      o_line_ff   <= o_line_in;
      o_track_ff  <= o_track_in;
      o_sector_ff <= o_sector_in;
      o_err_ff    <= o_err_in;
      o_last_ff   <= o_last_in;
      if (tag_we) begin
         line_device_ff[tag_addr] <= dev_ff;
         line_track_ff[tag_addr]  <= quo_ff[tbcl_pkg::TRACK_W-1:0];
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.hit             = o_hit_ff;
   assign rsp_if.line_index      = o_line_ff;
   assign rsp_if.track_number    = o_track_ff;
   assign rsp_if.sector_in_track = o_sector_ff;
   assign rsp_if.range_error     = o_err_ff;
   assign rsp_if.result_last     = o_last_ff;

`ifndef SYNTHESIS
   // out-of-range result carries the fixed miss fields
   a_range_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && o_err_ff |-> !o_hit_ff && (o_line_ff == '0)
                                   && (o_track_ff == tbcl_pkg::TRACK_SAT))
      else $error("range error result with lookup fields");

   // scan never walks past the lines in use
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> tbcl_pkg::CNT_W'(idx_ff) <= last_idx)
      else $error("scan index beyond lines in use");

   // a miss fill leaves the victim with counter one
   a_fill_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UPDATE && !hit_ff |=> use_count_ff[$past(victim_ff)] == tbcl_pkg::USE_FILL)
      else $error("victim counter not set on fill");

   // a hit always names a valid line
   a_hit_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UPDATE && hit_ff |-> use_count_ff[line_ff] != '0)
      else $error("hit on an invalid line");

   // range error skips the line scan
   a_err_skip: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV && state_in == S_DONE |-> err_in)
      else $error("divide ended straight into result without range error");
`endif

endmodule
